@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define SKL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition leads to a consequence in the next cycle
`define SKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/skl_pkg.sv @@
`timescale 1ns / 1ps

package skl_pkg;

  localparam int VAL_W  = 32;
  localparam int RANK_W = 4;
  localparam int KEEP_W = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd10;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    end_of_stream;
  } skl_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] smallest_value;
    logic [RANK_W-1:0]       rank_position;
    logic                    last_of_run;
  } skl_out_t;

  typedef struct packed {
    logic upd;
    logic clear;
  } skl_ctl_t;

endpackage

@@ src/streaming_k_smallest.sv @@
`timescale 1ns / 1ps
// Streaming k-smallest selection.
// Input beats (in_valid / in_stall) carry a signed sample and an end flag. The block
// keeps the keep_count smallest samples of the current stream in a sorted register
// store; each sample is compared against every kept entry in parallel and shifted in,
// so one input beat is taken per cycle unless in_stall holds an end beat.
// On the beat with end_of_stream set, the updated list moves into a drain buffer and
// the store empties for the next stream. The drain buffer sends one result beat per
// cycle while out_stall is low (out_valid / out_stall), in ascending order, rank 0
// first, last_of_run on the final one; the input stage register loads the buffer.
// While a run drains, non-end samples of the next stream are still taken; a second
// end beat waits in the input stage until the drain buffer is empty or sending its
// last beat, and in_stall is raised meanwhile.
// A stalled result beat holds until taken.
// cfg_valid / cfg_ready writes keep_count (always ready); write it only when idle.
// Reset: keep_count returns to 10, the store and drain buffer empty, no beat pending.
module streaming_k_smallest import skl_pkg::*; #(
  parameter int MAX_KEEP = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  skl_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output skl_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KEEP_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int LW = (CW > KEEP_W) ? CW : KEEP_W;

  logic [KEEP_W-1:0]              keep_r;
  logic [LW-1:0]                  keep_ext;
  logic [CW-1:0]                  lim;

  skl_in_t                        item_r;
  logic                           item_vld_r;
  logic                           stage_hold;
  logic                           stage_fire;
  skl_ctl_t                       ctl;

  logic [MAX_KEEP-1:0][VAL_W-1:0] vals_nxt;
  logic [CW-1:0]                  cnt_nxt;

  logic [MAX_KEEP-1:0][VAL_W-1:0] drn_vals_r;
  logic [CW-1:0]                  drn_left_r;
  logic [RANK_W-1:0]              rank_r;
  logic                           out_pop;
  logic                           drn_free;
  logic                           drn_load;

  logic                           step_pop;
  logic signed [VAL_W-1:0]        head_val;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      keep_r <= cfg_data;
    end
  end

  // clamp the limit to 1..MAX_KEEP
  always_comb begin
    keep_ext = LW'(keep_r);
    if (keep_ext == '0) begin
      lim = CW'(1);
    end else if (keep_ext > LW'(MAX_KEEP)) begin
      lim = CW'(MAX_KEEP);
    end else begin
      lim = CW'(keep_ext);
    end
  end

  // drain buffer and input stage handshake
  assign out_valid = (drn_left_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign drn_free  = (drn_left_r == '0) || ((drn_left_r == CW'(1)) && out_pop);

  assign stage_hold = item_vld_r && item_r.end_of_stream && !drn_free;
  assign stage_fire = item_vld_r && !stage_hold;
  assign in_stall   = stage_hold;
  assign drn_load   = stage_fire && item_r.end_of_stream;

  assign ctl.upd   = stage_fire;
  assign ctl.clear = item_r.end_of_stream;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!stage_hold) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stage_hold && in_valid) begin
      item_r <= in_data;
    end
  end

  skl_sort_store #(
    .MAX_KEEP (MAX_KEEP),
    .CW       (CW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sample   (item_r.sample_value),
    .lim      (lim),
    .vals_nxt (vals_nxt),
    .cnt_nxt  (cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drn_left_r <= '0;
    end else if (drn_load) begin
      drn_left_r <= cnt_nxt;
    end else if (out_pop) begin
      drn_left_r <= drn_left_r - CW'(1);
    end
  end

  // advance toward entry 0 on each beat sent
  always_ff @(posedge clk) begin
    if (drn_load) begin
      drn_vals_r <= vals_nxt;
      rank_r     <= '0;
    end else if (out_pop) begin
      for (int i = 0; i < MAX_KEEP - 1; i++) begin
        drn_vals_r[i] <= drn_vals_r[i + 1];
      end
      rank_r <= rank_r + RANK_W'(1);
    end
  end

  assign out_data.smallest_value = drn_vals_r[0];
  assign out_data.rank_position  = rank_r;
  assign out_data.last_of_run    = (drn_left_r == CW'(1));

  assign step_pop = out_pop && !out_data.last_of_run;
  assign head_val = out_data.smallest_value;

  `SKL_ASSERT(a_stall_end, in_stall |-> (item_vld_r && item_r.end_of_stream), "stray stall")
  `SKL_ASSERT_NEXT(a_ascend, step_pop, out_valid && (head_val >= $past(head_val)), "not ascending")
  `SKL_ASSERT_NEXT(a_rank, step_pop, rank_r == $past(rank_r) + RANK_W'(1), "rank skipped")

endmodule

@@ src/skl_sort_store.sv @@
`timescale 1ns / 1ps

module skl_sort_store import skl_pkg::*; #(
  parameter int MAX_KEEP = 16,
  parameter int CW       = $clog2(MAX_KEEP + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  skl_ctl_t                            ctl,
  input  logic signed [VAL_W-1:0]             sample,
  input  logic [CW-1:0]                       lim,
  output logic [MAX_KEEP-1:0][VAL_W-1:0]      vals_nxt,
  output logic [CW-1:0]                       cnt_nxt
);

  logic [MAX_KEEP-1:0][VAL_W-1:0] vals_r;
  logic [CW-1:0]                  cnt_r;
  logic [CW-1:0]                  cnt_cut;
  logic [MAX_KEEP-1:0]            le;

  // cut the list to the current limit, then place the sample after all entries <= it
  always_comb begin
    cnt_cut = (cnt_r > lim) ? lim : cnt_r;
    for (int i = 0; i < MAX_KEEP; i++) begin
      le[i] = (CW'(i) < cnt_cut) && ($signed(vals_r[i]) <= sample);
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (le[i]) begin
        vals_nxt[i] = vals_r[i];
      end else if (i == 0) begin
        vals_nxt[i] = sample;
      end else if (le[(i > 0) ? i - 1 : 0]) begin
        vals_nxt[i] = sample;
      end else begin
        vals_nxt[i] = vals_r[(i > 0) ? i - 1 : 0];
      end
    end
    cnt_nxt = (cnt_cut < lim) ? cnt_cut + CW'(1) : cnt_cut;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.upd) begin
      cnt_r <= ctl.clear ? '0 : cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      vals_r <= vals_nxt;
    end
  end

endmodule

@@ verif/streaming_k_smallest_tb.sv @@
`timescale 1ns / 1ps

module streaming_k_smallest_tb;
  import skl_pkg::*;

  localparam int MAX_KEEP = 16;
  localparam int RANDOM_ITEMS = 265;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  class k_smallest_sb;
    logic signed [VAL_W-1:0] kept_vals[MAX_KEEP];
    int unsigned kept_n;
    logic [KEEP_W-1:0] keep_reg;
    skl_out_t expected_ranks[$];
    int mismatches;

    function new();
      kept_n = 0;
      keep_reg = KEEP_RESET;
      mismatches = 0;
      foreach (kept_vals[i]) kept_vals[i] = '0;
    endfunction

    function void set_keep(logic [KEEP_W-1:0] v);
      keep_reg = v;
    endfunction

    function int pending();
      return expected_ranks.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_sample(skl_in_t beat);
      logic signed [VAL_W-1:0] v;
      int unsigned lim;
      int unsigned pos;
      int unsigned top;
      skl_out_t e;
      v = beat.sample_value;
      lim = (keep_reg == 0) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : keep_reg);
      if (kept_n > lim) kept_n = lim;
      pos = 0;
      while (pos < kept_n && kept_vals[pos] <= v) pos++;
      if (pos < lim) begin
        top = (kept_n < lim) ? kept_n : lim - 1;
        for (int unsigned i = top; i > pos; i--) kept_vals[i] = kept_vals[i-1];
        kept_vals[pos] = v;
        if (kept_n < lim) kept_n++;
      end
      if (beat.end_of_stream) begin
        for (int unsigned r = 0; r < kept_n; r++) begin
          e.smallest_value = kept_vals[r];
          e.rank_position = RANK_W'(r);
          e.last_of_run = (r + 1 == kept_n);
          expected_ranks.push_back(e);
        end
        kept_n = 0;
      end
    endfunction

    task check_result(skl_out_t got);
      skl_out_t exp_beat;
      if (expected_ranks.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected: value %0d rank %0d last %0b",
                                  got.smallest_value, got.rank_position, got.last_of_run));
        return;
      end
      exp_beat = expected_ranks.pop_front();
      if (got.smallest_value !== exp_beat.smallest_value)
        report_mismatch($sformatf("smallest_value got %0d expected %0d",
                                  got.smallest_value, exp_beat.smallest_value));
      if (got.rank_position !== exp_beat.rank_position)
        report_mismatch($sformatf("rank_position got %0d expected %0d",
                                  got.rank_position, exp_beat.rank_position));
      if (got.last_of_run !== exp_beat.last_of_run)
        report_mismatch($sformatf("last_of_run got %0b expected %0b (rank %0d)",
                                  got.last_of_run, exp_beat.last_of_run,
                                  exp_beat.rank_position));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  skl_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  skl_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [KEEP_W-1:0] cfg_data = '0;

  logic calm = 1'b0;
  int items_sent = 0;
  int cycles = 0;
  k_smallest_sb sb = new();

  streaming_k_smallest #(.MAX_KEEP(MAX_KEEP)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_keep(cfg_data);
      if (in_valid && !in_stall) sb.note_sample(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 34);
  end

  task automatic send_value(logic signed [VAL_W-1:0] v, logic eos);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_value: v, end_of_stream: eos};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_keep(logic [KEEP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_stream(int len);
    for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
  endtask

  initial begin
    int phase;
    int base;
    int len;
    logic [KEEP_W-1:0] keep;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit, extremes of the value range
    send_value(32'sh7fffffff, 1'b0);
    send_value(32'sh80000000, 1'b0);
    send_value(32'sh00000000, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sd5, 1'b1);

    // full list of one: ties with the largest are dropped
    wait_idle();
    write_keep(5'd1);
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd3, 1'b1);

    // lower the limit mid-stream
    wait_idle();
    write_keep(5'd16);
    send_value(32'sd9, 1'b0);
    send_value(32'sd8, 1'b0);
    send_value(32'sd7, 1'b0);
    send_value(32'sd6, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd4, 1'b0);
    wait_idle();
    write_keep(5'd3);
    send_value(32'sd4, 1'b1);

    // zero acts as one
    wait_idle();
    write_keep(5'd0);
    send_value(-32'sd7, 1'b0);
    send_value(-32'sd7, 1'b1);

    // above the maximum acts as the maximum; duplicates kept
    wait_idle();
    write_keep(5'd31);
    repeat (4) send_value(32'sd2, 1'b0);
    send_value(32'sd2, 1'b1);

    base = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      wait_idle();
      case (phase % 6)
        0: keep = 5'd17;
        1: keep = 5'd16;
        2: keep = 5'd2;
        3: keep = 5'd1;
        default: keep = 5'($urandom_range(0, 31));
      endcase
      calm = (phase == 1);
      write_keep(keep);
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 20);
        send_stream(len);
      end
      phase++;
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ streaming_k_smallest.f @@
+incdir+src
src/skl_pkg.sv
src/skl_sort_store.sv
src/streaming_k_smallest.sv
verif/streaming_k_smallest_tb.sv
